### sv/fclm_pkg.sv
// Shared types and constants for the allocation table link manager.
package fclm_pkg;

    localparam int LINKS        = 4096;
    localparam int SECTOR_BYTES = 1024;
    localparam int IDX_W        = $clog2(LINKS);
    localparam int LINK_W       = 16;
    localparam int LBA_W        = 17;
    localparam int CNT_W        = 11;

    localparam logic [7:0] FULL_MARK = 8'hff;

    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_CHECK  = 3'd1;
    localparam logic [2:0] CMD_ALLOC  = 3'd2;
    localparam logic [2:0] CMD_FOLLOW = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [1:0] TAIL_FULL  = 2'd0;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [LINK_W-1:0] link_t;

    typedef struct packed {
        logic  we;
        idx_t  waddr;
        link_t wdata;
        idx_t  raddr;
    } ram_req_t;

    typedef struct packed {
        link_t            link_out;
        logic [LBA_W-1:0] next_lba;
        logic [CNT_W-1:0] byte_count;
        logic             chain_end;
        logic             space_ok;
        logic             bad_address;
    } res_t;

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_READ       = 7'b0000010,
        S_WALK       = 7'b0000100,
        S_ALLOC      = 7'b0001000,
        S_ALLOC_HEAD = 7'b0010000,
        S_ALLOC_TAIL = 7'b0100000,
        S_FOLLOW     = 7'b1000000
    } state_t;

endpackage

### sv/fclm_link_ram.sv
// Link table memory: one write port, one registered read port.
module fclm_link_ram
(
    input  logic               clk,
    input  fclm_pkg::ram_req_t req,
    output fclm_pkg::link_t    rdata
);

    fclm_pkg::link_t mem [fclm_pkg::LINKS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

### sv/fclm_seq.sv
// Command sequencer with the shared sector address adder.
module fclm_seq
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [7:0]                       fat_sectors,
    input  logic [2:0]                       command,
    input  logic [15:0]                      link_index,
    input  logic [15:0]                      link_value,
    input  logic [15:0]                      block_count,
    input  logic                             is_last,
    input  logic [1:0]                       tail_mode,
    input  logic [16:0]                      sector_lba,
    input  logic [7:0]                       last_byte,
    input  logic [9:0]                       tail_count,
    output fclm_pkg::ram_req_t               ram_req,
    input  fclm_pkg::link_t                  rdata,
    output logic                             done,
    output fclm_pkg::res_t                   res
);

    fclm_pkg::state_t state_reg, state_next;
    fclm_pkg::link_t  cursor_reg, cursor_next;
    fclm_pkg::link_t  work_reg, work_next;
    logic [15:0]      cnt_reg, cnt_next;
    logic [15:0]      step_reg, step_next;
    logic             last_reg, last_next;
    logic [1:0]       mode_reg, mode_next;
    logic [7:0]       lbyte_reg, lbyte_next;
    logic [9:0]       tcnt_reg, tcnt_next;
    logic             done_reg, done_next;
    fclm_pkg::res_t   res_reg, res_next;

    fclm_pkg::link_t  lba_op;
    logic [17:0]      lba_wide;
    logic [16:0]      lba_sum;
    logic [17:0]      fidx;
    logic             fbad;
    logic             accept;
    logic             idx_ok;
    logic             rd_ok;
    logic [15:0]      step_inc;

    assign busy   = (state_reg != fclm_pkg::S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign res    = res_reg;

    // shared adder: link to sector address
    assign lba_op   = (state_reg == fclm_pkg::S_ALLOC_TAIL) ? work_reg : rdata;
    assign lba_wide = 18'(lba_op) + 18'(fat_sectors) + 18'h1ffff;
    assign lba_sum  = lba_wide[16:0];

    assign fidx     = 18'(sector_lba) + 18'd1 - 18'(fat_sectors);
    assign fbad     = (sector_lba < 17'(fat_sectors)) || (fidx >= 18'(fclm_pkg::LINKS));
    assign idx_ok   = (17'(link_index) < 17'(fclm_pkg::LINKS));
    assign rd_ok    = (17'(rdata) < 17'(fclm_pkg::LINKS));
    assign step_inc = step_reg + 16'd1;

    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        work_next   = work_reg;
        cnt_next    = cnt_reg;
        step_next   = step_reg;
        last_next   = last_reg;
        mode_next   = mode_reg;
        lbyte_next  = lbyte_reg;
        tcnt_next   = tcnt_reg;
        done_next   = 1'b0;
        res_next    = '0;
        ram_req     = '0;

        unique case (state_reg)
            fclm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        fclm_pkg::CMD_LOAD:
                        begin
                            ram_req.we    = idx_ok;
                            ram_req.waddr = link_index[fclm_pkg::IDX_W-1:0];
                            ram_req.wdata = link_value;
                            done_next     = 1'b1;
                        end
                        fclm_pkg::CMD_CHECK:
                        begin
                            if (block_count == 16'd0)
                            begin
                                res_next.space_ok = 1'b1;
                                done_next         = 1'b1;
                            end
                            else
                            begin
                                ram_req.raddr = '0;
                                cnt_next      = block_count;
                                step_next     = '0;
                                state_next    = fclm_pkg::S_WALK;
                            end
                        end
                        fclm_pkg::CMD_ALLOC:
                        begin
                            ram_req.raddr = cursor_reg[fclm_pkg::IDX_W-1:0];
                            last_next     = is_last;
                            mode_next     = tail_mode;
                            state_next    = fclm_pkg::S_ALLOC;
                        end
                        fclm_pkg::CMD_FOLLOW:
                        begin
                            if (fbad)
                            begin
                                res_next.bad_address = 1'b1;
                                res_next.chain_end   = 1'b1;
                                done_next            = 1'b1;
                            end
                            else
                            begin
                                ram_req.raddr = fidx[fclm_pkg::IDX_W-1:0];
                                work_next     = fidx[15:0];
                                lbyte_next    = last_byte;
                                tcnt_next     = tail_count;
                                state_next    = fclm_pkg::S_FOLLOW;
                            end
                        end
                        fclm_pkg::CMD_READ:
                        begin
                            if (idx_ok)
                            begin
                                ram_req.raddr = link_index[fclm_pkg::IDX_W-1:0];
                                state_next    = fclm_pkg::S_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            fclm_pkg::S_READ:
            begin
                res_next.link_out = rdata;
                done_next         = 1'b1;
                state_next        = fclm_pkg::S_IDLE;
            end
            fclm_pkg::S_WALK:
            begin
                priority if (rdata == '0)
                begin
                    done_next  = 1'b1;
                    state_next = fclm_pkg::S_IDLE;
                end
                else if (step_inc == cnt_reg)
                begin
                    res_next.space_ok = 1'b1;
                    done_next         = 1'b1;
                    state_next        = fclm_pkg::S_IDLE;
                end
                else if (!rd_ok)
                begin
                    done_next  = 1'b1;
                    state_next = fclm_pkg::S_IDLE;
                end
                else
                begin
                    ram_req.raddr = rdata[fclm_pkg::IDX_W-1:0];
                    step_next     = step_inc;
                end
            end
            fclm_pkg::S_ALLOC:
            begin
                priority if (rdata == '0 || !rd_ok)
                begin
                    res_next.bad_address = 1'b1;
                    done_next            = 1'b1;
                    state_next           = fclm_pkg::S_IDLE;
                end
                else if (!last_reg)
                begin
                    res_next.next_lba = lba_sum;
                    cursor_next       = rdata;
                    done_next         = 1'b1;
                    state_next        = fclm_pkg::S_IDLE;
                end
                else
                begin
                    work_next     = rdata;
                    ram_req.raddr = rdata[fclm_pkg::IDX_W-1:0];
                    state_next    = fclm_pkg::S_ALLOC_HEAD;
                end
            end
            fclm_pkg::S_ALLOC_HEAD:
            begin
                // free head takes the popped block's successor
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wdata = rdata;
                state_next    = fclm_pkg::S_ALLOC_TAIL;
            end
            fclm_pkg::S_ALLOC_TAIL:
            begin
                ram_req.we        = 1'b1;
                ram_req.waddr     = work_reg[fclm_pkg::IDX_W-1:0];
                ram_req.wdata     = (mode_reg == fclm_pkg::TAIL_FULL) ? '0 : work_reg;
                cursor_next       = '0;
                res_next.next_lba = lba_sum;
                done_next         = 1'b1;
                state_next        = fclm_pkg::S_IDLE;
            end
            fclm_pkg::S_FOLLOW:
            begin
                priority if (rdata == work_reg)
                begin
                    res_next.chain_end = 1'b1;
                    if (lbyte_reg == fclm_pkg::FULL_MARK)
                    begin
                        res_next.byte_count = 11'(fclm_pkg::SECTOR_BYTES - 1);
                    end
                    else if (11'(tcnt_reg) > 11'(fclm_pkg::SECTOR_BYTES))
                    begin
                        res_next.byte_count = 11'(fclm_pkg::SECTOR_BYTES);
                    end
                    else
                    begin
                        res_next.byte_count = 11'(tcnt_reg);
                    end
                end
                else if (rdata == '0)
                begin
                    res_next.chain_end  = 1'b1;
                    res_next.byte_count = 11'(fclm_pkg::SECTOR_BYTES);
                end
                else
                begin
                    res_next.next_lba   = lba_sum;
                    res_next.byte_count = 11'(fclm_pkg::SECTOR_BYTES);
                end
                done_next  = 1'b1;
                state_next = fclm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = fclm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= fclm_pkg::S_IDLE;
            cursor_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        cnt_reg   <= cnt_next;
        step_reg  <= step_next;
        last_reg  <= last_next;
        mode_reg  <= mode_next;
        lbyte_reg <= lbyte_next;
        tcnt_reg  <= tcnt_next;
        res_reg   <= res_next;
    end

endmodule

### sv/fat_chain_link_manager_unit.sv
// Load, rejected commands and a zero-count space check need no table read; read,
// follow and allocate read one link, allocate on the final block also reads its
// successor and writes head and tail, space check walks up to block_count links. One
// command at a time; busy is high while a table-reading command runs. Each link step
// is one read on the RAM's single read port. Result beats are a one-cycle done pulse.
// Async reset clears the sequencer, cursor and fat_sectors (to 1), not the link RAM.
module fat_chain_link_manager_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [15:0] link_index,
    input  logic [15:0] link_value,
    input  logic [15:0] block_count,
    input  logic        is_last,
    input  logic [1:0]  tail_mode,
    input  logic [16:0] sector_lba,
    input  logic [7:0]  last_byte,
    input  logic [9:0]  tail_count,
    output logic        done,
    output logic [15:0] link_out,
    output logic [16:0] next_lba,
    output logic [10:0] byte_count,
    output logic        chain_end,
    output logic        space_ok,
    output logic        bad_address
);

    logic [7:0]         fat_sectors_reg;
    fclm_pkg::ram_req_t ram_req;
    fclm_pkg::link_t    rdata;
    fclm_pkg::res_t     res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fat_sectors_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            fat_sectors_reg <= cfg_data;
        end
    end

    fclm_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .fat_sectors (fat_sectors_reg),
        .command     (command),
        .link_index  (link_index),
        .link_value  (link_value),
        .block_count (block_count),
        .is_last     (is_last),
        .tail_mode   (tail_mode),
        .sector_lba  (sector_lba),
        .last_byte   (last_byte),
        .tail_count  (tail_count),
        .ram_req     (ram_req),
        .rdata       (rdata),
        .done        (done),
        .res         (res)
    );

    fclm_link_ram u_ram
    (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    assign link_out    = res.link_out;
    assign next_lba    = res.next_lba;
    assign byte_count  = res.byte_count;
    assign chain_end   = res.chain_end;
    assign space_ok    = res.space_ok;
    assign bad_address = res.bad_address;

endmodule

### sv/fclm_checker.sv
// Port-level checks for the link manager, bound to the top level.
module fclm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  command,
    input logic        done,
    input logic [16:0] next_lba,
    input logic [10:0] byte_count,
    input logic        space_ok,
    input logic        bad_address
);

    // load finishes without going busy
    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command == fclm_pkg::CMD_LOAD |=> done && !busy)
        else $error("load did not complete in one cycle");

    // allocate always needs a table read
    a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command == fclm_pkg::CMD_ALLOC |=> busy && !done)
        else $error("allocate did not go busy");

    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && bad_address |-> next_lba == '0 && byte_count == '0 && !space_ok)
        else $error("bad address beat carries data");

    a_bytes_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> byte_count <= 11'(fclm_pkg::SECTOR_BYTES))
        else $error("byte count past sector size");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

endmodule

bind fat_chain_link_manager_unit fclm_checker u_fclm_checker (.*);

### tb/sv/fat_chain_link_manager_unit_tb.sv
// Self-checking testbench: directed and random command beats checked against a table-walking predictor.
`timescale 1ns / 1ps

module fat_chain_link_manager_unit_tb;

    import fclm_pkg::*;

    localparam int          PHASES           = 6;
    localparam int          ITEMS_PER_PHASE  = 325;
    localparam int          WATCHDOG_LIMIT   = 400000;
    localparam int          DRAIN_CYCLES     = 20;
    localparam int          MAX_REPORTS      = 10;
    localparam logic [2:0]  CMD_SPARE_FIRST  = 3'd5;
    localparam logic [2:0]  CMD_SPARE_LAST   = 3'd7;
    localparam logic [1:0]  TAIL_SHORTER_ALT = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] link_index;
        logic [15:0] link_value;
        logic [15:0] block_count;
        logic        is_last;
        logic [1:0]  tail_mode;
        logic [16:0] sector_lba;
        logic [7:0]  last_byte;
        logic [9:0]  tail_count;
    } cmd_item_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [7:0]  cfg_data    = '0;
    logic        start       = 1'b0;
    logic        busy;
    logic [2:0]  command     = '0;
    logic [15:0] link_index  = '0;
    logic [15:0] link_value  = '0;
    logic [15:0] block_count = '0;
    logic        is_last     = 1'b0;
    logic [1:0]  tail_mode   = '0;
    logic [16:0] sector_lba  = '0;
    logic [7:0]  last_byte   = '0;
    logic [9:0]  tail_count  = '0;
    logic        done;
    logic [15:0] link_out;
    logic [16:0] next_lba;
    logic [10:0] byte_count;
    logic        chain_end;
    logic        space_ok;
    logic        bad_address;

    // predictor state
    logic [15:0] link_mem [0:LINKS-1];
    int unsigned alloc_cur  = 0;
    int unsigned sec_offset = 1;

    // stimulus bookkeeping
    cmd_item_t   cmd_queue[$];
    res_t        due_results[$];
    bit          written_map [0:LINKS-1];
    int unsigned written_list[$];
    int          phase_items = 0;
    int          mismatches  = 0;
    int unsigned gap_left    = 0;
    int unsigned no_gap_run  = 0;
    int unsigned stall_cycles = 0;
    cmd_item_t   beat_on_pins;

    fat_chain_link_manager_unit u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .link_index  (link_index),
        .link_value  (link_value),
        .block_count (block_count),
        .is_last     (is_last),
        .tail_mode   (tail_mode),
        .sector_lba  (sector_lba),
        .last_byte   (last_byte),
        .tail_count  (tail_count),
        .done        (done),
        .link_out    (link_out),
        .next_lba    (next_lba),
        .byte_count  (byte_count),
        .chain_end   (chain_end),
        .space_ok    (space_ok),
        .bad_address (bad_address)
    );

    always #6 clk = ~clk;

    function automatic int unsigned link_at(int unsigned i);
        if (i >= LINKS)
            return 0;
        return 32'(link_mem[i]);
    endfunction

    function automatic void link_put(int unsigned i, int unsigned v);
        if (i < LINKS)
            link_mem[i] = v[15:0];
    endfunction

    function automatic logic [16:0] sector_of(int unsigned lnk);
        logic [16:0] s;
        s = 17'(lnk + sec_offset - 1);
        return s;
    endfunction

    function automatic res_t fat_apply(cmd_item_t it);
        res_t        r;
        int unsigned n;
        int unsigned cur;
        int unsigned lnk;
        int unsigned idx;
        bit          walking;
        r = '0;
        case (it.command)
            CMD_LOAD: link_put(32'(it.link_index), 32'(it.link_value));
            CMD_CHECK:
            begin
                n       = 0;
                cur     = 0;
                walking = 1'b1;
                while (walking && n < 32'(it.block_count))
                begin
                    cur = link_at(cur);
                    if (cur == 0)
                        walking = 1'b0;
                    else
                        n++;
                end
                r.space_ok = (n == 32'(it.block_count));
            end
            CMD_ALLOC:
            begin
                lnk = link_at(alloc_cur);
                if (lnk == 0 || lnk >= LINKS)
                    r.bad_address = 1'b1;
                else
                begin
                    r.next_lba = sector_of(lnk);
                    if (it.is_last)
                    begin
                        link_put(0, link_at(lnk));
                        link_put(lnk, (it.tail_mode == TAIL_FULL) ? 32'd0 : lnk);
                        alloc_cur = 0;
                    end
                    else
                        alloc_cur = lnk;
                end
            end
            CMD_FOLLOW:
            begin
                idx = 32'(it.sector_lba) + 1 - sec_offset;
                if (32'(it.sector_lba) < sec_offset || idx >= LINKS)
                begin
                    r.bad_address = 1'b1;
                    r.chain_end   = 1'b1;
                end
                else
                begin
                    lnk = link_at(idx);
                    if (lnk == idx)
                    begin
                        r.chain_end = 1'b1;
                        if (it.last_byte == FULL_MARK)
                            r.byte_count = 11'(SECTOR_BYTES - 1);
                        else if (32'(it.tail_count) > SECTOR_BYTES)
                            r.byte_count = 11'(SECTOR_BYTES);
                        else
                            r.byte_count = 11'(it.tail_count);
                    end
                    else if (lnk == 0)
                    begin
                        r.chain_end  = 1'b1;
                        r.byte_count = 11'(SECTOR_BYTES);
                    end
                    else
                    begin
                        r.next_lba   = sector_of(lnk);
                        r.byte_count = 11'(SECTOR_BYTES);
                    end
                end
            end
            CMD_READ: r.link_out = 16'(link_at(32'(it.link_index)));
            default: ;
        endcase
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gap_run > 0)
        begin
            no_gap_run--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            no_gap_run = $urandom_range(20, 100);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 60);
    endfunction

    // driver: one command beat per start/!busy edge
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
                due_results.push_back(fat_apply(beat_on_pins));
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (cmd_queue.size() > 0)
                begin
                    beat_on_pins = cmd_queue.pop_front();
                    command     <= beat_on_pins.command;
                    link_index  <= beat_on_pins.link_index;
                    link_value  <= beat_on_pins.link_value;
                    block_count <= beat_on_pins.block_count;
                    is_last     <= beat_on_pins.is_last;
                    tail_mode   <= beat_on_pins.tail_mode;
                    sector_lba  <= beat_on_pins.sector_lba;
                    last_byte   <= beat_on_pins.last_byte;
                    tail_count  <= beat_on_pins.tail_count;
                    start       <= 1'b1;
                    gap_left     = pick_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic log_mismatch(string what, res_t want, res_t got);
        if (mismatches < MAX_REPORTS)
        begin
            $display("%0t %s exp: link=%h lba=%h bytes=%0d end=%b ok=%b bad=%b",
                     $time, what, want.link_out, want.next_lba, want.byte_count,
                     want.chain_end, want.space_ok, want.bad_address);
            $display("%0t %s got: link=%h lba=%h bytes=%0d end=%b ok=%b bad=%b",
                     $time, what, got.link_out, got.next_lba, got.byte_count,
                     got.chain_end, got.space_ok, got.bad_address);
        end
        mismatches++;
    endtask

    // monitor: result beats are single-cycle done pulses
    always @(posedge clk)
    begin : monitor
        res_t got;
        res_t want;
        if (rst_n && done)
        begin
            got = {link_out, next_lba, byte_count, chain_end, space_ok, bad_address};
            if (due_results.size() == 0)
                log_mismatch("unexpected result", '0, got);
            else
            begin
                want = due_results.pop_front();
                if (got !== want)
                    log_mismatch("result mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic cmd_item_t rand_item(logic [2:0] cmd);
        logic [95:0] bits;
        cmd_item_t   it;
        bits       = {$urandom, $urandom, $urandom};
        it         = bits[$bits(cmd_item_t)-1:0];
        it.command = cmd;
        return it;
    endfunction

    task automatic q_push(cmd_item_t it);
        cmd_queue.push_back(it);
        phase_items++;
    endtask

    task automatic q_load(int unsigned idx, int unsigned val);
        cmd_item_t it;
        it            = rand_item(CMD_LOAD);
        it.link_index = 16'(idx);
        it.link_value = 16'(val);
        if (idx < LINKS && !written_map[idx])
        begin
            written_map[idx] = 1'b1;
            written_list.push_back(idx);
        end
        q_push(it);
    endtask

    task automatic q_read(int unsigned idx);
        cmd_item_t it;
        it            = rand_item(CMD_READ);
        it.link_index = 16'(idx);
        q_push(it);
    endtask

    task automatic q_check(int unsigned cnt);
        cmd_item_t it;
        it             = rand_item(CMD_CHECK);
        it.block_count = 16'(cnt);
        q_push(it);
    endtask

    task automatic q_alloc(logic last, logic [1:0] mode);
        cmd_item_t it;
        it           = rand_item(CMD_ALLOC);
        it.is_last   = last;
        it.tail_mode = mode;
        q_push(it);
    endtask

    task automatic q_follow(logic [16:0] lba, logic [7:0] lbyte, logic [9:0] tcnt);
        cmd_item_t it;
        it            = rand_item(CMD_FOLLOW);
        it.sector_lba = lba;
        it.last_byte  = lbyte;
        it.tail_count = tcnt;
        q_push(it);
    endtask

    function automatic int unsigned pick_written();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    // link values only ever point at written entries, zero or past the table
    function automatic int unsigned pick_link(int unsigned self_idx);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 0;
        if (r < 20)
            return $urandom_range(LINKS, 16'hFFFF);
        if (r < 30)
            return self_idx;
        return pick_written();
    endfunction

    function automatic logic [16:0] bad_sector();
        if (sec_offset > 0 && $urandom_range(0, 1) == 0)
            return 17'($urandom_range(0, sec_offset - 1));
        return 17'($urandom_range(LINKS + sec_offset - 1, 17'h1FFFF));
    endfunction

    function automatic logic [7:0] pick_last_byte();
        if ($urandom_range(0, 99) < 30)
            return FULL_MARK;
        return 8'($urandom_range(0, 8'hFF));
    endfunction

    task automatic run_directed();
        q_load(9, 0);
        q_load(5, 9);
        q_load(0, 5);
        q_load(16'hFFFF, 16'hFFFF);
        q_load(LINKS - 1, LINKS - 1);
        q_read(0);
        q_read(16'hFFFF);
        q_read(LINKS - 1);
        q_check(0);
        q_check(2);
        q_check(3);
        q_check(16'hFFFF);
        q_alloc(1'b0, TAIL_FULL);
        q_alloc(1'b1, TAIL_FULL);
        q_alloc(1'b1, TAIL_FULL);     // empty free list
        q_follow(sector_of(5), 8'h00, 10'd0);
        q_follow(sector_of(9), 8'h00, 10'd0);
        q_follow(sector_of(LINKS - 1), FULL_MARK, 10'd0);
        q_follow(sector_of(LINKS - 1), 8'h00, 10'h3FF);
        q_follow(17'd0, 8'h00, 10'd0);
        q_follow(sector_of(LINKS), 8'h00, 10'd0);
        q_push(rand_item(CMD_SPARE_FIRST));
        q_push(rand_item(CMD_SPARE_LAST));
        q_load(0, LINKS - 1);
        q_alloc(1'b1, TAIL_SHORTER_ALT);
    endtask

    // build a free chain, size-check it, write a file into it, then walk the file
    task automatic gen_file_scenario();
        int unsigned chain[$];
        int unsigned len;
        int unsigned nalloc;
        int unsigned j;
        len = $urandom_range(1, 12);
        repeat (len) chain.push_back($urandom_range(1, LINKS - 1));
        q_load(chain[len-1], ($urandom_range(0, 9) == 0) ? $urandom_range(LINKS, 16'hFFFF) : 0);
        for (j = len - 1; j > 0; j--)
            q_load(chain[j-1], chain[j]);
        q_load(0, chain[0]);
        q_check(len);
        q_check($urandom_range(0, len + 2));
        nalloc = ($urandom_range(0, 9) == 0) ? len + 1 : $urandom_range(1, len);
        for (j = 0; j + 1 < nalloc; j++)
            q_alloc(1'b0, 2'($urandom_range(0, 3)));
        if ($urandom_range(0, 9) != 0)
            q_alloc(1'b1, 2'($urandom_range(0, 3)));
        for (j = 0; j < nalloc && j < len; j++)
            q_follow(sector_of(chain[j]), pick_last_byte(), 10'($urandom_range(0, 10'h3FF)));
        if ($urandom_range(0, 1) == 0)
            q_read(chain[$urandom_range(0, len - 1)]);
    endtask

    task automatic gen_noise();
        int unsigned r;
        int unsigned idx;
        case ($urandom_range(0, 7))
            0, 1:
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    q_load($urandom_range(LINKS, 16'hFFFF), $urandom_range(0, 16'hFFFF));
                else
                begin
                    idx = (r < 60) ? $urandom_range(0, LINKS - 1) : pick_written();
                    q_load(idx, pick_link(idx));
                end
            end
            2: q_read(($urandom_range(0, 3) == 0) ? $urandom_range(LINKS, 16'hFFFF)
                                                  : pick_written());
            3: q_check(($urandom_range(0, 39) == 0) ? $urandom_range(0, 16'hFFFF)
                                                    : $urandom_range(0, 20));
            4: q_alloc(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            5, 6:
            begin
                if ($urandom_range(0, 9) < 3)
                    q_follow(bad_sector(), pick_last_byte(), 10'($urandom_range(0, 10'h3FF)));
                else
                    q_follow(sector_of(pick_written()), pick_last_byte(),
                             10'($urandom_range(0, 10'h3FF)));
            end
            default: q_push(rand_item(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST))));
        endcase
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (cmd_queue.size() != 0 || start || due_results.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_fat_sectors(int unsigned v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= 8'(v);
        @(posedge clk);
        cfg_we   <= 1'b0;
        sec_offset = v;
    endtask

    function automatic int unsigned phase_setting(int p);
        case (p)
            1: return 128;
            2: return 0;
            3: return 255;
            4: return $urandom_range(2, 127);
            default: return 1;
        endcase
    endfunction

    initial
    begin : stimulus
        int p;
        foreach (link_mem[i])
            link_mem[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        for (p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_idle();
                write_fat_sectors(phase_setting(p));
            end
            phase_items = 0;
            if (p == 0)
                run_directed();
            while (phase_items < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 99) < 75)
                    gen_file_scenario();
                else
                    repeat ($urandom_range(1, 3)) gen_noise();
            end
        end
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
sv/fclm_pkg.sv
sv/fclm_link_ram.sv
sv/fclm_seq.sv
sv/fat_chain_link_manager_unit.sv
sv/fclm_checker.sv
tb/sv/fat_chain_link_manager_unit_tb.sv
